// ----- src/cpu8085_execute_unit_defines.svh -----
// assertion macros shared by the execute unit
`ifndef CPU8085_EXECUTE_UNIT_DEFINES_SVH
`define CPU8085_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define C85EU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("c85eu assertion failed");

// next-cycle implication, checked while out of reset
`define C85EU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("c85eu assertion failed");

`endif

// ----- src/c85eu_pkg.sv -----
// shared constants, opcodes and types of the execute unit
`default_nettype none
package c85eu_pkg;

   localparam int MEM_ADDR_BITS = 16;
   localparam int PORT_COUNT    = 256;
   localparam int PORT_BITS     = $clog2(PORT_COUNT);
   localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
   localparam logic [8:0] PORT_LIMIT = 9'(PORT_COUNT);
   localparam logic [MEM_ADDR_BITS:0] PORT_END = (MEM_ADDR_BITS + 1)'(PORT_COUNT);

   localparam logic [6:0] OP_INX  = 7'd0;
   localparam logic [6:0] OP_DCX  = 7'd1;
   localparam logic [6:0] OP_DAD  = 7'd2;
   localparam logic [6:0] OP_LXI  = 7'd3;
   localparam logic [6:0] OP_MVI  = 7'd4;
   localparam logic [6:0] OP_MOV  = 7'd5;
   localparam logic [6:0] OP_ADD  = 7'd6;
   localparam logic [6:0] OP_SUB  = 7'd7;
   localparam logic [6:0] OP_JM   = 7'd8;
   localparam logic [6:0] OP_ADC  = 7'd9;
   localparam logic [6:0] OP_SBB  = 7'd10;
   localparam logic [6:0] OP_ADI  = 7'd11;
   localparam logic [6:0] OP_ACI  = 7'd12;
   localparam logic [6:0] OP_SUI  = 7'd13;
   localparam logic [6:0] OP_SBI  = 7'd14;
   localparam logic [6:0] OP_ANI  = 7'd15;
   localparam logic [6:0] OP_ORI  = 7'd16;
   localparam logic [6:0] OP_XRI  = 7'd17;
   localparam logic [6:0] OP_CPI  = 7'd18;
   localparam logic [6:0] OP_RAL  = 7'd19;
   localparam logic [6:0] OP_RAR  = 7'd20;
   localparam logic [6:0] OP_LHLD = 7'd21;
   localparam logic [6:0] OP_SHLD = 7'd22;
   localparam logic [6:0] OP_LDAX = 7'd23;
   localparam logic [6:0] OP_STAX = 7'd24;
   localparam logic [6:0] OP_XCHG = 7'd25;
   localparam logic [6:0] OP_CALL = 7'd26;
   localparam logic [6:0] OP_RET  = 7'd27;
   localparam logic [6:0] OP_CZ   = 7'd28;
   localparam logic [6:0] OP_CNZ  = 7'd29;
   localparam logic [6:0] OP_RZ   = 7'd30;
   localparam logic [6:0] OP_RNZ  = 7'd31;
   localparam logic [6:0] OP_OUT  = 7'd32;
   localparam logic [6:0] OP_IN   = 7'd33;
   localparam logic [6:0] OP_NOP  = 7'd34;
   localparam logic [6:0] OP_INR  = 7'd39;
   localparam logic [6:0] OP_DCR  = 7'd40;
   localparam logic [6:0] OP_LDA  = 7'd41;
   localparam logic [6:0] OP_STA  = 7'd42;
   localparam logic [6:0] OP_JMP  = 7'd43;
   localparam logic [6:0] OP_JZ   = 7'd44;
   localparam logic [6:0] OP_JNZ  = 7'd45;
   localparam logic [6:0] OP_JNC  = 7'd46;
   localparam logic [6:0] OP_PUSH = 7'd47;
   localparam logic [6:0] OP_POP  = 7'd48;
   localparam logic [6:0] OP_JP   = 7'd49;
   localparam logic [6:0] OP_JPE  = 7'd50;
   localparam logic [6:0] OP_JPO  = 7'd51;
   localparam logic [6:0] OP_CC   = 7'd52;
   localparam logic [6:0] OP_CNC  = 7'd53;
   localparam logic [6:0] OP_CP   = 7'd54;
   localparam logic [6:0] OP_CM   = 7'd55;
   localparam logic [6:0] OP_CPE  = 7'd56;
   localparam logic [6:0] OP_CPO  = 7'd57;
   localparam logic [6:0] OP_RC   = 7'd58;
   localparam logic [6:0] OP_RNC  = 7'd59;
   localparam logic [6:0] OP_RP   = 7'd60;
   localparam logic [6:0] OP_RM   = 7'd61;
   localparam logic [6:0] OP_RPE  = 7'd62;
   localparam logic [6:0] OP_RPO  = 7'd63;
   localparam logic [6:0] OP_RST  = 7'd64;
   localparam logic [6:0] OP_SPHL = 7'd65;
   localparam logic [6:0] OP_PCHL = 7'd66;
   localparam logic [6:0] OP_CMA  = 7'd67;
   localparam logic [6:0] OP_CMC  = 7'd68;
   localparam logic [6:0] OP_STC  = 7'd69;
   localparam logic [6:0] OP_DAA  = 7'd70;

   localparam logic [1:0] CL_NONE = 2'd0;
   localparam logic [1:0] CL_JMP  = 2'd1;
   localparam logic [1:0] CL_CALL = 2'd2;
   localparam logic [1:0] CL_RET  = 2'd3;

   localparam logic [3:0] COND_T  = 4'd0;
   localparam logic [3:0] COND_Z  = 4'd1;
   localparam logic [3:0] COND_NZ = 4'd2;
   localparam logic [3:0] COND_C  = 4'd3;
   localparam logic [3:0] COND_NC = 4'd4;
   localparam logic [3:0] COND_P  = 4'd5;
   localparam logic [3:0] COND_M  = 4'd6;
   localparam logic [3:0] COND_PE = 4'd7;
   localparam logic [3:0] COND_PO = 4'd8;

   localparam logic [2:0] REG_A = 3'd0;
   localparam logic [2:0] REG_B = 3'd1;
   localparam logic [2:0] REG_C = 3'd2;
   localparam logic [2:0] REG_D = 3'd3;
   localparam logic [2:0] REG_E = 3'd4;
   localparam logic [2:0] REG_H = 3'd5;
   localparam logic [2:0] REG_L = 3'd6;
   localparam logic [2:0] REG_M = 3'd7;

   localparam logic [1:0] PAIR_BC   = 2'd0;
   localparam logic [1:0] PAIR_DE   = 2'd1;
   localparam logic [1:0] PAIR_HL   = 2'd2;
   localparam logic [1:0] PAIR_NONE = 2'd3;

   localparam int FLAG_CY = 0;
   localparam int FLAG_Z  = 1;
   localparam int FLAG_S  = 2;
   localparam int FLAG_P  = 3;

   typedef struct packed {
      logic [6:0]  action;
      logic [2:0]  dst_reg;
      logic [2:0]  src_reg;
      logic [1:0]  pair;
      logic [15:0] imm;
      logic [1:0]  cls;
      logic [3:0]  cond;
      logic        src_m;
      logic        dst_m;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } head_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_stat_type;

endpackage
`default_nettype wire

// ----- src/c85eu_intf.sv -----
// handshake channels for operations and results
`default_nettype none
interface c85eu_req_if;
   logic        valid;
   logic        ready;
   logic [6:0]  action;
   logic [2:0]  dst_reg;
   logic [2:0]  src_reg;
   logic [1:0]  pair;
   logic [15:0] imm;

   modport source (output valid, action, dst_reg, src_reg, pair, imm, input ready);
   modport sink (input valid, action, dst_reg, src_reg, pair, imm, output ready);
endinterface

interface c85eu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  acc;
   logic [15:0] reg_bc;
   logic [15:0] reg_de;
   logic [15:0] reg_hl;
   logic [15:0] stack_ptr;
   logic [15:0] prog_counter;
   logic [3:0]  flags;
   logic        port_wr;
   logic [7:0]  port_addr;
   logic [7:0]  port_data;

   modport source (output valid, acc, reg_bc, reg_de, reg_hl, stack_ptr, prog_counter,
                   flags, port_wr, port_addr, port_data, input ready);
   modport sink (input valid, acc, reg_bc, reg_de, reg_hl, stack_ptr, prog_counter,
                 flags, port_wr, port_addr, port_data, output ready);
endinterface
`default_nettype wire

// ----- src/cpu8085_execute_unit.sv -----
// execute unit for decoded 8085-style operations
// req_ch carries one decoded operation per transaction (action, register codes,
// pair code, immediate); rsp_ch returns one transaction per operation with the
// machine state after it and any port write done by OUT.
// A two-entry queue sits in front of the execute sequencer, so req_ch can take up
// to two transactions while the sequencer works or a result waits on rsp_ch.
// Sequencer steps per operation: register-only operations finish in ST_ISSUE;
// one memory or port read goes through ST_RD1, two memory writes (SHLD, PUSH,
// CALL, RST) through ST_WR2, and two reads (LHLD, POP, taken returns) through
// ST_RD1 and ST_RD2; the single data memory port sets this.
// After reset the data memory and port table are swept to zero, one entry a
// cycle through all 65536 memory entries; rsp_ch gives nothing until the sweep ends, and req_ch
// fills the queue and then holds ready low.
// When rsp_ch stalls, the finished result is held and the sequencer waits;
// the queue then fills and ready drops.
`default_nettype none
`include "cpu8085_execute_unit_defines.svh"
module cpu8085_execute_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   c85eu_req_if.sink   req_ch,
   c85eu_rsp_if.source rsp_ch
);
   import c85eu_pkg::*;

   head_type      head;
   back_stat_type bk_stat;

   c85eu_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .head  (head),
      .pop   (bk_stat.pop)
   );

   c85eu_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .stat  (bk_stat),
      .rsp   (rsp_ch)
   );

   `C85EU_ASSERT_NOW(a_pop_has_item, bk_stat.pop, head.valid)
   `C85EU_ASSERT_NOW(a_no_pop_clearing, bk_stat.clearing, !bk_stat.pop)
   `C85EU_ASSERT_NEXT(a_no_rsp_clearing, bk_stat.clearing, !rsp_ch.valid)

endmodule
`default_nettype wire

// ----- src/c85eu_front.sv -----
// front end: accepts operations, classifies them and queues them for the back end
`default_nettype none
module c85eu_front (
   input  wire logic              clock,
   input  wire logic              reset,
   c85eu_req_if.sink              req,
   output c85eu_pkg::head_type    head,
   input  wire logic              pop
);
   import c85eu_pkg::*;

   op_type      dec;
   op_type      q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   logic        take;

   always_comb begin
      dec.action  = req.action;
      dec.dst_reg = req.dst_reg;
      dec.src_reg = req.src_reg;
      dec.pair    = req.pair;
      dec.imm     = req.imm;
      dec.cls     = CL_NONE;
      dec.cond    = COND_T;
      case (req.action)
         OP_JMP:  begin dec.cls = CL_JMP;  dec.cond = COND_T;  end
         OP_JM:   begin dec.cls = CL_JMP;  dec.cond = COND_M;  end
         OP_JZ:   begin dec.cls = CL_JMP;  dec.cond = COND_Z;  end
         OP_JNZ:  begin dec.cls = CL_JMP;  dec.cond = COND_NZ; end
         OP_JNC:  begin dec.cls = CL_JMP;  dec.cond = COND_NC; end
         OP_JP:   begin dec.cls = CL_JMP;  dec.cond = COND_P;  end
         OP_JPE:  begin dec.cls = CL_JMP;  dec.cond = COND_PE; end
         OP_JPO:  begin dec.cls = CL_JMP;  dec.cond = COND_PO; end
         OP_CALL: begin dec.cls = CL_CALL; dec.cond = COND_T;  end
         OP_CZ:   begin dec.cls = CL_CALL; dec.cond = COND_Z;  end
         OP_CNZ:  begin dec.cls = CL_CALL; dec.cond = COND_NZ; end
         OP_CC:   begin dec.cls = CL_CALL; dec.cond = COND_C;  end
         OP_CNC:  begin dec.cls = CL_CALL; dec.cond = COND_NC; end
         OP_CP:   begin dec.cls = CL_CALL; dec.cond = COND_P;  end
         OP_CM:   begin dec.cls = CL_CALL; dec.cond = COND_M;  end
         OP_CPE:  begin dec.cls = CL_CALL; dec.cond = COND_PE; end
         OP_CPO:  begin dec.cls = CL_CALL; dec.cond = COND_PO; end
         OP_RET:  begin dec.cls = CL_RET;  dec.cond = COND_T;  end
         OP_RZ:   begin dec.cls = CL_RET;  dec.cond = COND_Z;  end
         OP_RNZ:  begin dec.cls = CL_RET;  dec.cond = COND_NZ; end
         OP_RC:   begin dec.cls = CL_RET;  dec.cond = COND_C;  end
         OP_RNC:  begin dec.cls = CL_RET;  dec.cond = COND_NC; end
         OP_RP:   begin dec.cls = CL_RET;  dec.cond = COND_P;  end
         OP_RM:   begin dec.cls = CL_RET;  dec.cond = COND_M;  end
         OP_RPE:  begin dec.cls = CL_RET;  dec.cond = COND_PE; end
         OP_RPO:  begin dec.cls = CL_RET;  dec.cond = COND_PO; end
         default: begin dec.cls = CL_NONE; dec.cond = COND_T;  end
      endcase
      dec.src_m = (req.src_reg == REG_M) &&
                  (req.action == OP_MOV || req.action == OP_ADD || req.action == OP_SUB ||
                   req.action == OP_ADC || req.action == OP_SBB);
      dec.dst_m = (req.dst_reg == REG_M) &&
                  (req.action == OP_MVI || req.action == OP_MOV || req.action == OP_INR ||
                   req.action == OP_DCR);
   end

   assign req.ready  = (cnt_ff != 2'd2);
   assign push       = req.valid && req.ready;
   assign take       = pop && (cnt_ff != 2'd0);
   assign head.valid = (cnt_ff != 2'd0);
   assign head.op    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule
`default_nettype wire

// ----- src/c85eu_back.sv -----
// back end: register file, data memory, i/o ports and the execute sequencer
`default_nettype none
module c85eu_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire c85eu_pkg::head_type  head,
   output c85eu_pkg::back_stat_type  stat,
   c85eu_rsp_if.source               rsp
);
   import c85eu_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_ISSUE = 3'd1;
   localparam logic [2:0] ST_RD1   = 3'd2;
   localparam logic [2:0] ST_RD2   = 3'd3;
   localparam logic [2:0] ST_WR2   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [MEM_ADDR_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   op_type      cur_ff, cur_in;
   logic [7:0]  d1_ff, d1_in;
   logic [15:0] wr2_addr_ff, wr2_addr_in;
   logic [7:0]  wr2_data_ff, wr2_data_in;

   logic [7:0]  acc_ff, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff;
   logic [3:0]  flags_ff;
   logic [15:0] sp_ff, pc_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_acc_ff;
   logic [15:0] rsp_bc_ff, rsp_de_ff, rsp_hl_ff, rsp_sp_ff, rsp_pc_ff;
   logic [3:0]  rsp_flags_ff;
   logic        rsp_pw_ff;
   logic [7:0]  rsp_pa_ff, rsp_pd_ff;

   logic [7:0]  mem [MEM_DEPTH];
   logic [7:0]  ports [PORT_COUNT];
   logic [7:0]  mem_q_ff, port_q_ff;
   logic        mem_we, mem_re, port_we, port_re;
   logic [MEM_ADDR_BITS-1:0] mem_addr;
   logic [7:0]  mem_wd, port_wd;
   logic [PORT_BITS-1:0] port_addr;

   op_type      ex;
   logic        out_free, finish, pop;
   logic        cond_ok, cy;
   logic [15:0] hl, pv, next_pc;
   logic [7:0]  ib;
   logic        port_ok;

   // memory accesses planned at issue
   logic        p_rd, p_rd_port, p_wr, p_wr2, p_port_wr;
   logic [15:0] p_addr, p_wr2_addr;
   logic [7:0]  p_wd, p_wr2_data;
   logic        two_rd;

   // new architectural state
   logic [7:0]  d1_sel, rd_src, rd_dst, incdec;
   logic [7:0]  n_acc, n_b, n_c, n_d, n_e, n_h, n_l;
   logic [3:0]  n_flags;
   logic [15:0] n_sp, n_pc;
   logic        n_pw;
   logic [7:0]  n_pa, n_pd;
   logic [7:0]  alu_b;
   logic        alu_c;
   logic [8:0]  sum9;
   logic [16:0] dad17;
   logic [7:0]  daa1, daa2;

   function automatic logic [7:0] pick(input logic [2:0] code, input logic [7:0] a,
                                       input logic [7:0] b, input logic [7:0] c,
                                       input logic [7:0] d, input logic [7:0] e,
                                       input logic [7:0] h, input logic [7:0] l,
                                       input logic [7:0] m);
      logic [7:0] v;
      case (code)
         REG_A:   v = a;
         REG_B:   v = b;
         REG_C:   v = c;
         REG_D:   v = d;
         REG_E:   v = e;
         REG_H:   v = h;
         REG_L:   v = l;
         default: v = m;
      endcase
      return v;
   endfunction

   // parity set for an even number of ones, carry kept
   function automatic logic [3:0] zsp(input logic [7:0] v, input logic c);
      return {~^v, v[7], (v == 8'd0), c};
   endfunction

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign ex       = (state_ff == ST_ISSUE) ? head.op : cur_ff;
   assign hl       = {h_ff, l_ff};
   assign ib       = ex.imm[7:0];
   assign cy       = flags_ff[FLAG_CY];
   assign next_pc  = pc_ff + 16'd1;
   assign port_ok  = ({1'b0, ib} < PORT_LIMIT);

   always_comb begin
      case (ex.pair)
         PAIR_BC: pv = {b_ff, c_ff};
         PAIR_DE: pv = {d_ff, e_ff};
         PAIR_HL: pv = hl;
         default: pv = 16'd0;
      endcase
      case (ex.cond)
         COND_T:  cond_ok = 1'b1;
         COND_Z:  cond_ok = flags_ff[FLAG_Z];
         COND_NZ: cond_ok = !flags_ff[FLAG_Z];
         COND_C:  cond_ok = cy;
         COND_NC: cond_ok = !cy;
         COND_P:  cond_ok = !flags_ff[FLAG_S];
         COND_M:  cond_ok = flags_ff[FLAG_S];
         COND_PE: cond_ok = flags_ff[FLAG_P];
         COND_PO: cond_ok = !flags_ff[FLAG_P];
         default: cond_ok = 1'b0;
      endcase
   end

   // memory traffic of the issue cycle
   always_comb begin
      p_rd       = 1'b0;
      p_rd_port  = 1'b0;
      p_wr       = 1'b0;
      p_wr2      = 1'b0;
      p_port_wr  = 1'b0;
      p_addr     = hl;
      p_wd       = 8'd0;
      p_wr2_addr = 16'd0;
      p_wr2_data = 8'd0;
      case (ex.action)
         OP_MOV: begin
            if (ex.src_m) begin
               p_rd = 1'b1;
            end else if (ex.dst_m) begin
               p_wr = 1'b1;
               p_wd = pick(ex.src_reg, acc_ff, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff, 8'd0);
            end
         end
         OP_ADD, OP_SUB, OP_ADC, OP_SBB: p_rd = ex.src_m;
         OP_MVI: begin
            p_wr = ex.dst_m;
            p_wd = ib;
         end
         OP_INR, OP_DCR: p_rd = ex.dst_m;
         OP_LDAX: begin
            p_rd   = 1'b1;
            p_addr = pv;
         end
         OP_LDA, OP_LHLD: begin
            p_rd   = 1'b1;
            p_addr = ex.imm;
         end
         OP_IN: p_rd_port = 1'b1;
         OP_STAX: begin
            p_wr   = 1'b1;
            p_addr = pv;
            p_wd   = acc_ff;
         end
         OP_STA: begin
            p_wr   = 1'b1;
            p_addr = ex.imm;
            p_wd   = acc_ff;
         end
         OP_SHLD: begin
            p_wr       = 1'b1;
            p_addr     = ex.imm;
            p_wd       = l_ff;
            p_wr2      = 1'b1;
            p_wr2_addr = ex.imm + 16'd1;
            p_wr2_data = h_ff;
         end
         OP_PUSH: begin
            if (ex.pair != PAIR_NONE) begin
               p_wr       = 1'b1;
               p_addr     = sp_ff - 16'd1;
               p_wd       = pv[15:8];
               p_wr2      = 1'b1;
               p_wr2_addr = sp_ff - 16'd2;
               p_wr2_data = pv[7:0];
            end
         end
         OP_POP: begin
            p_rd   = (ex.pair != PAIR_NONE);
            p_addr = sp_ff;
         end
         OP_RST: begin
            p_wr       = 1'b1;
            p_addr     = sp_ff - 16'd1;
            p_wd       = next_pc[15:8];
            p_wr2      = 1'b1;
            p_wr2_addr = sp_ff - 16'd2;
            p_wr2_data = next_pc[7:0];
         end
         OP_OUT: p_port_wr = port_ok;
         default: begin
            if (ex.cls == CL_CALL && cond_ok) begin
               p_wr       = 1'b1;
               p_addr     = sp_ff - 16'd1;
               p_wd       = next_pc[15:8];
               p_wr2      = 1'b1;
               p_wr2_addr = sp_ff - 16'd2;
               p_wr2_data = next_pc[7:0];
            end else if (ex.cls == CL_RET && cond_ok) begin
               p_rd   = 1'b1;
               p_addr = sp_ff;
            end
         end
      endcase
   end

   assign two_rd = (cur_ff.action == OP_LHLD) || (cur_ff.action == OP_POP) ||
                   (cur_ff.cls == CL_RET);

   // execute: state after the operation
   always_comb begin
      d1_sel = (state_ff == ST_RD2) ? d1_ff : mem_q_ff;
      rd_src = pick(ex.src_reg, acc_ff, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff, d1_sel);
      rd_dst = pick(ex.dst_reg, acc_ff, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff, d1_sel);
      incdec = (ex.action == OP_INR) ? rd_dst + 8'd1 : rd_dst - 8'd1;
      n_acc   = acc_ff;
      n_b     = b_ff;
      n_c     = c_ff;
      n_d     = d_ff;
      n_e     = e_ff;
      n_h     = h_ff;
      n_l     = l_ff;
      n_flags = flags_ff;
      n_sp    = sp_ff;
      n_pc    = next_pc;
      n_pw    = 1'b0;
      n_pa    = 8'd0;
      n_pd    = 8'd0;
      alu_b   = (ex.action == OP_ADI || ex.action == OP_ACI || ex.action == OP_SUI ||
                 ex.action == OP_SBI) ? ib : rd_src;
      alu_c   = (ex.action == OP_ADC || ex.action == OP_ACI || ex.action == OP_SBB ||
                 ex.action == OP_SBI) && cy;
      sum9    = {1'b0, acc_ff} + {1'b0, alu_b} + {8'd0, alu_c};
      dad17   = {1'b0, hl} + {1'b0, pv};
      daa1    = (acc_ff[3:0] > 4'd9) ? acc_ff + 8'h06 : acc_ff;
      daa2    = daa1;
      case (ex.action)
         OP_INX, OP_DCX, OP_LXI: begin
            logic [15:0] w;
            w = (ex.action == OP_INX) ? pv + 16'd1 :
                (ex.action == OP_DCX) ? pv - 16'd1 : ex.imm;
            case (ex.pair)
               PAIR_BC: {n_b, n_c} = w;
               PAIR_DE: {n_d, n_e} = w;
               PAIR_HL: {n_h, n_l} = w;
               default: ;
            endcase
         end
         OP_DAD: begin
            {n_h, n_l}       = dad17[15:0];
            n_flags[FLAG_CY] = dad17[16];
         end
         OP_MVI, OP_MOV, OP_INR, OP_DCR: begin
            logic [7:0] v;
            v = (ex.action == OP_MVI) ? ib : (ex.action == OP_MOV) ? rd_src : incdec;
            case (ex.dst_reg)
               REG_A:   n_acc = v;
               REG_B:   n_b = v;
               REG_C:   n_c = v;
               REG_D:   n_d = v;
               REG_E:   n_e = v;
               REG_H:   n_h = v;
               REG_L:   n_l = v;
               default: ;
            endcase
            if (ex.action == OP_INR || ex.action == OP_DCR) begin
               n_flags = zsp(v, cy);
            end
         end
         OP_ADD, OP_ADC, OP_ADI, OP_ACI: begin
            n_acc   = sum9[7:0];
            n_flags = zsp(sum9[7:0], sum9[8]);
         end
         OP_SUB, OP_SBB, OP_SUI, OP_SBI: begin
            n_acc   = acc_ff - alu_b - {7'd0, alu_c};
            n_flags = zsp(n_acc, {1'b0, acc_ff} < ({1'b0, alu_b} + {8'd0, alu_c}));
         end
         OP_ANI: begin
            n_acc   = acc_ff & ib;
            n_flags = zsp(n_acc, 1'b0);
         end
         OP_ORI: begin
            n_acc   = acc_ff | ib;
            n_flags = zsp(n_acc, 1'b0);
         end
         OP_XRI: begin
            n_acc   = acc_ff ^ ib;
            n_flags = zsp(n_acc, 1'b0);
         end
         OP_CPI:  n_flags = zsp(acc_ff - ib, acc_ff < ib);
         OP_RAL: begin
            n_acc            = {acc_ff[6:0], cy};
            n_flags[FLAG_CY] = acc_ff[7];
         end
         OP_RAR: begin
            n_acc            = {cy, acc_ff[7:1]};
            n_flags[FLAG_CY] = acc_ff[0];
         end
         OP_LHLD: begin
            n_l = d1_sel;
            n_h = mem_q_ff;
         end
         OP_LDAX, OP_LDA: n_acc = d1_sel;
         OP_XCHG: begin
            n_d = h_ff;
            n_e = l_ff;
            n_h = d_ff;
            n_l = e_ff;
         end
         OP_OUT: begin
            n_pw = port_ok;
            n_pa = port_ok ? ib : 8'd0;
            n_pd = port_ok ? acc_ff : 8'd0;
         end
         OP_IN:   n_acc = port_ok ? port_q_ff : 8'd0;
         OP_PUSH: begin
            if (ex.pair != PAIR_NONE) begin
               n_sp = sp_ff - 16'd2;
            end
         end
         OP_POP: begin
            case (ex.pair)
               PAIR_BC: {n_b, n_c} = {mem_q_ff, d1_sel};
               PAIR_DE: {n_d, n_e} = {mem_q_ff, d1_sel};
               PAIR_HL: {n_h, n_l} = {mem_q_ff, d1_sel};
               default: ;
            endcase
            if (ex.pair != PAIR_NONE) begin
               n_sp = sp_ff + 16'd2;
            end
         end
         OP_RST: begin
            n_sp = sp_ff - 16'd2;
            n_pc = {10'd0, ex.imm[2:0], 3'd0};
         end
         OP_SPHL: n_sp = hl;
         OP_PCHL: n_pc = hl;
         OP_CMA:  n_acc = ~acc_ff;
         OP_CMC:  n_flags[FLAG_CY] = !cy;
         OP_STC:  n_flags[FLAG_CY] = 1'b1;
         OP_DAA: begin
            if (daa1[7:4] > 4'd9 || cy) begin
               daa2 = daa1 + 8'h60;
            end
            n_acc   = daa2;
            n_flags = zsp(daa2, cy || daa1[7:4] > 4'd9);
         end
         default: begin
            if (cond_ok) begin
               case (ex.cls)
                  CL_JMP:  n_pc = ex.imm;
                  CL_CALL: begin
                     n_sp = sp_ff - 16'd2;
                     n_pc = ex.imm;
                  end
                  CL_RET: begin
                     n_sp = sp_ff + 16'd2;
                     n_pc = {mem_q_ff, d1_sel};
                  end
                  default: ;
               endcase
            end
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      cur_in      = cur_ff;
      d1_in       = d1_ff;
      wr2_addr_in = wr2_addr_ff;
      wr2_data_in = wr2_data_ff;
      finish      = 1'b0;
      pop         = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = p_addr[MEM_ADDR_BITS-1:0];
      mem_wd      = p_wd;
      port_we     = 1'b0;
      port_re     = 1'b0;
      port_addr   = ib[PORT_BITS-1:0];
      port_wd     = acc_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_addr   = clr_cnt_ff;
            mem_wd     = 8'd0;
            port_we    = ({1'b0, clr_cnt_ff} < PORT_END);
            port_addr  = clr_cnt_ff[PORT_BITS-1:0];
            port_wd    = 8'd0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (head.valid && out_free) begin
               pop    = 1'b1;
               cur_in = head.op;
               if (p_rd || p_rd_port) begin
                  mem_re   = p_rd;
                  port_re  = p_rd_port;
                  state_in = ST_RD1;
               end else begin
                  mem_we  = p_wr;
                  port_we = p_port_wr;
                  if (p_wr2) begin
                     wr2_addr_in = p_wr2_addr;
                     wr2_data_in = p_wr2_data;
                     state_in    = ST_WR2;
                  end else begin
                     finish = 1'b1;
                  end
               end
            end
         end
         ST_RD1: begin
            if (out_free) begin
               if (two_rd) begin
                  d1_in    = mem_q_ff;
                  mem_re   = 1'b1;
                  mem_addr = (cur_ff.action == OP_LHLD) ?
                             cur_in.imm[MEM_ADDR_BITS-1:0] + 1'b1 :
                             sp_ff[MEM_ADDR_BITS-1:0] + 1'b1;
                  state_in = ST_RD2;
               end else begin
                  // a single read finishes here; INR or DCR of M writes the byte at hl back
                  mem_we   = cur_ff.dst_m &&
                             (cur_ff.action == OP_INR || cur_ff.action == OP_DCR);
                  mem_addr = hl[MEM_ADDR_BITS-1:0];
                  mem_wd   = incdec;
                  finish   = 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_RD2: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_WR2: begin
            if (out_free) begin
               mem_we   = 1'b1;
               mem_addr = wr2_addr_ff[MEM_ADDR_BITS-1:0];
               mem_wd   = wr2_data_ff;
               finish   = 1'b1;
               state_in = ST_ISSUE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      rsp_valid_in = finish || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
         b_ff         <= 8'd0;
         c_ff         <= 8'd0;
         d_ff         <= 8'd0;
         e_ff         <= 8'd0;
         h_ff         <= 8'd0;
         l_ff         <= 8'd0;
         flags_ff     <= 4'd0;
         sp_ff        <= 16'd0;
         pc_ff        <= 16'd0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            acc_ff   <= n_acc;
            b_ff     <= n_b;
            c_ff     <= n_c;
            d_ff     <= n_d;
            e_ff     <= n_e;
            h_ff     <= n_h;
            l_ff     <= n_l;
            flags_ff <= n_flags;
            sp_ff    <= n_sp;
            pc_ff    <= n_pc;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      d1_ff       <= d1_in;
      wr2_addr_ff <= wr2_addr_in;
      wr2_data_ff <= wr2_data_in;
      if (finish) begin
         rsp_acc_ff   <= n_acc;
         rsp_bc_ff    <= {n_b, n_c};
         rsp_de_ff    <= {n_d, n_e};
         rsp_hl_ff    <= {n_h, n_l};
         rsp_sp_ff    <= n_sp;
         rsp_pc_ff    <= n_pc;
         rsp_flags_ff <= n_flags;
         rsp_pw_ff    <= n_pw;
         rsp_pa_ff    <= n_pa;
         rsp_pd_ff    <= n_pd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (port_we) begin
         ports[port_addr] <= port_wd;
      end
      if (port_re) begin
         port_q_ff <= ports[port_addr];
      end
   end

   assign stat.clearing    = (state_ff == ST_CLEAR);
   assign stat.pop         = pop;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.acc          = rsp_acc_ff;
   assign rsp.reg_bc       = rsp_bc_ff;
   assign rsp.reg_de       = rsp_de_ff;
   assign rsp.reg_hl       = rsp_hl_ff;
   assign rsp.stack_ptr    = rsp_sp_ff;
   assign rsp.prog_counter = rsp_pc_ff;
   assign rsp.flags        = rsp_flags_ff;
   assign rsp.port_wr      = rsp_pw_ff;
   assign rsp.port_addr    = rsp_pa_ff;
   assign rsp.port_data    = rsp_pd_ff;

endmodule
`default_nettype wire

// ----- tb/tb_cpu8085_execute_unit_pkg.sv -----
// scoreboard class with the execute unit's behavioral model
`timescale 1ns / 100ps
package tb_cpu8085_execute_unit_pkg;
   import c85eu_pkg::*;

   typedef struct packed {
      logic [7:0]  acc;
      logic [15:0] reg_bc;
      logic [15:0] reg_de;
      logic [15:0] reg_hl;
      logic [15:0] stack_ptr;
      logic [15:0] prog_counter;
      logic [3:0]  flags;
      logic        port_wr;
      logic [7:0]  port_addr;
      logic [7:0]  port_data;
   } state_word_type;

   class exec_scoreboard;
      logic [7:0]  a;
      logic [7:0]  gpr [6];
      logic [3:0]  fl;
      logic [15:0] sp;
      logic [15:0] pc;
      logic [7:0]  mem [int];
      logic [7:0]  ports [256];
      state_word_type pending [$];
      int          n_errors;
      int          n_checked;

      function new();
         a = 0; fl = 0; sp = 0; pc = 0; n_errors = 0; n_checked = 0;
         foreach (gpr[i]) gpr[i] = 0;
         foreach (ports[i]) ports[i] = 0;
      endfunction

      function logic [7:0] rd_mem(logic [15:0] addr);
         return mem.exists(addr) ? mem[addr] : 8'h00;
      endfunction

      function void wr_mem(logic [15:0] addr, logic [7:0] v);
         mem[addr] = v;
      endfunction

      function logic [15:0] hl();
         return {gpr[4], gpr[5]};
      endfunction

      function logic [7:0] rd_reg(logic [2:0] code);
         if (code == REG_A) return a;
         if (code == REG_M) return rd_mem(hl());
         return gpr[code - 1];
      endfunction

      function void wr_reg(logic [2:0] code, logic [7:0] v);
         if (code == REG_A) a = v;
         else if (code == REG_M) wr_mem(hl(), v);
         else gpr[code - 1] = v;
      endfunction

      function logic [15:0] rd_pair(logic [1:0] p);
         if (p == PAIR_NONE) return 16'h0;
         return {gpr[2 * p], gpr[2 * p + 1]};
      endfunction

      function void wr_pair(logic [1:0] p, logic [15:0] v);
         if (p == PAIR_NONE) return;
         gpr[2 * p] = v[15:8];
         gpr[2 * p + 1] = v[7:0];
      endfunction

      function void set_zsp(logic [7:0] v);
         fl[FLAG_Z] = (v == 0);
         fl[FLAG_S] = v[7];
         fl[FLAG_P] = ~^v;
      endfunction

      function void add8(logic [7:0] b, logic c);
         logic [8:0] r;
         r = a + b + c;
         fl[FLAG_CY] = r[8];
         a = r[7:0];
         set_zsp(a);
      endfunction

      function void sub8(logic [7:0] b, logic c);
         fl[FLAG_CY] = ({1'b0, a} < ({1'b0, b} + c));
         a = a - b - c;
         set_zsp(a);
      endfunction

      function void push16(logic [15:0] w);
         sp = sp - 1; wr_mem(sp, w[15:8]);
         sp = sp - 1; wr_mem(sp, w[7:0]);
      endfunction

      function logic [15:0] pop16();
         logic [7:0] lo;
         lo = rd_mem(sp); sp = sp + 1;
         pop16 = {rd_mem(sp), lo}; sp = sp + 1;
      endfunction

      // work out the machine state after one accepted operation
      function void note_operation(logic [6:0] act, logic [2:0] dst, logic [2:0] src,
                                   logic [1:0] pr, logic [15:0] imm);
         logic cy, z, s, p, cond;
         logic [15:0] nxt;
         logic [16:0] t;
         logic [7:0] ib, old;
         state_word_type r;
         cy = fl[FLAG_CY]; z = fl[FLAG_Z]; s = fl[FLAG_S]; p = fl[FLAG_P];
         ib = imm[7:0];
         nxt = pc + 1;
         r.port_wr = 0; r.port_addr = 0; r.port_data = 0;
         case (act)
            OP_INX: wr_pair(pr, rd_pair(pr) + 1);
            OP_DCX: wr_pair(pr, rd_pair(pr) - 1);
            OP_DAD: begin
               t = hl() + rd_pair(pr);
               fl[FLAG_CY] = t[16];
               wr_pair(PAIR_HL, t[15:0]);
            end
            OP_LXI: wr_pair(pr, imm);
            OP_MVI: wr_reg(dst, ib);
            OP_MOV: wr_reg(dst, rd_reg(src));
            OP_ADD: add8(rd_reg(src), 0);
            OP_SUB: sub8(rd_reg(src), 0);
            OP_ADC: add8(rd_reg(src), cy);
            OP_SBB: sub8(rd_reg(src), cy);
            OP_ADI: add8(ib, 0);
            OP_ACI: add8(ib, cy);
            OP_SUI: sub8(ib, 0);
            OP_SBI: sub8(ib, cy);
            OP_ANI: begin a = a & ib; fl[FLAG_CY] = 0; set_zsp(a); end
            OP_ORI: begin a = a | ib; fl[FLAG_CY] = 0; set_zsp(a); end
            OP_XRI: begin a = a ^ ib; fl[FLAG_CY] = 0; set_zsp(a); end
            OP_CPI: begin set_zsp(a - ib); fl[FLAG_CY] = (a < ib); end
            OP_RAL: begin old = a; a = {a[6:0], cy}; fl[FLAG_CY] = old[7]; end
            OP_RAR: begin old = a; a = {cy, a[7:1]}; fl[FLAG_CY] = old[0]; end
            OP_LHLD: begin gpr[5] = rd_mem(imm); gpr[4] = rd_mem(imm + 16'd1); end
            OP_SHLD: begin wr_mem(imm, gpr[5]); wr_mem(imm + 16'd1, gpr[4]); end
            OP_LDAX: a = rd_mem(rd_pair(pr));
            OP_STAX: wr_mem(rd_pair(pr), a);
            OP_XCHG: begin
               old = gpr[2]; gpr[2] = gpr[4]; gpr[4] = old;
               old = gpr[3]; gpr[3] = gpr[5]; gpr[5] = old;
            end
            OP_OUT: begin
               ports[ib] = a;
               r.port_wr = 1; r.port_addr = ib; r.port_data = a;
            end
            OP_IN: a = ports[ib];
            OP_INR: begin wr_reg(dst, rd_reg(dst) + 1); set_zsp(rd_reg(dst)); end
            OP_DCR: begin wr_reg(dst, rd_reg(dst) - 1); set_zsp(rd_reg(dst)); end
            OP_LDA: a = rd_mem(imm);
            OP_STA: wr_mem(imm, a);
            OP_PUSH: if (pr != PAIR_NONE) push16(rd_pair(pr));
            OP_POP: if (pr != PAIR_NONE) wr_pair(pr, pop16());
            OP_RST: begin push16(nxt); nxt = {10'd0, imm[2:0], 3'd0}; end
            OP_SPHL: sp = hl();
            OP_PCHL: nxt = hl();
            OP_CMA: a = ~a;
            OP_CMC: fl[FLAG_CY] = ~cy;
            OP_STC: fl[FLAG_CY] = 1;
            OP_DAA: begin
               if (a[3:0] > 9) a = a + 8'h06;
               if (a[7:4] > 9 || cy) begin a = a + 8'h60; fl[FLAG_CY] = 1; end
               set_zsp(a);
            end
            OP_JM, OP_JMP, OP_JZ, OP_JNZ, OP_JNC, OP_JP, OP_JPE, OP_JPO: begin
               case (act)
                  OP_JM: cond = s;
                  OP_JMP: cond = 1;
                  OP_JZ: cond = z;
                  OP_JNZ: cond = !z;
                  OP_JNC: cond = !cy;
                  OP_JP: cond = !s;
                  OP_JPE: cond = p;
                  default: cond = !p;
               endcase
               if (cond) nxt = imm;
            end
            OP_CALL, OP_CZ, OP_CNZ, OP_CC, OP_CNC, OP_CP, OP_CM, OP_CPE, OP_CPO: begin
               case (act)
                  OP_CALL: cond = 1;
                  OP_CZ: cond = z;
                  OP_CNZ: cond = !z;
                  OP_CC: cond = cy;
                  OP_CNC: cond = !cy;
                  OP_CP: cond = !s;
                  OP_CM: cond = s;
                  OP_CPE: cond = p;
                  default: cond = !p;
               endcase
               if (cond) begin push16(nxt); nxt = imm; end
            end
            OP_RET, OP_RZ, OP_RNZ, OP_RC, OP_RNC, OP_RP, OP_RM, OP_RPE, OP_RPO: begin
               case (act)
                  OP_RET: cond = 1;
                  OP_RZ: cond = z;
                  OP_RNZ: cond = !z;
                  OP_RC: cond = cy;
                  OP_RNC: cond = !cy;
                  OP_RP: cond = !s;
                  OP_RM: cond = s;
                  OP_RPE: cond = p;
                  default: cond = !p;
               endcase
               if (cond) nxt = pop16();
            end
            default: ;
         endcase
         pc = nxt;
         r.acc = a; r.reg_bc = rd_pair(PAIR_BC); r.reg_de = rd_pair(PAIR_DE);
         r.reg_hl = rd_pair(PAIR_HL); r.stack_ptr = sp; r.prog_counter = pc; r.flags = fl;
         pending.push_back(r);
      endfunction

      function void cmp(string name, logic [15:0] exp_v, logic [15:0] got_v);
         if (exp_v !== got_v) begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            n_errors++;
         end
      endfunction

      function void check_state(state_word_type got);
         state_word_type e;
         if (pending.size() == 0) begin
            $error("result transaction with nothing expected");
            n_errors++;
            return;
         end
         e = pending.pop_front();
         n_checked++;
         cmp("acc", e.acc, got.acc);
         cmp("reg_bc", e.reg_bc, got.reg_bc);
         cmp("reg_de", e.reg_de, got.reg_de);
         cmp("reg_hl", e.reg_hl, got.reg_hl);
         cmp("stack_ptr", e.stack_ptr, got.stack_ptr);
         cmp("prog_counter", e.prog_counter, got.prog_counter);
         cmp("flags", e.flags, got.flags);
         cmp("port_wr", e.port_wr, got.port_wr);
         cmp("port_addr", e.port_addr, got.port_addr);
         cmp("port_data", e.port_data, got.port_data);
      endfunction
   endclass
endpackage

// ----- tb/tb_cpu8085_execute_unit.sv -----
// testbench top: drives decoded operations and checks every machine-state result
`timescale 1ns / 100ps
module tb_cpu8085_execute_unit;
   import c85eu_pkg::*;
   import tb_cpu8085_execute_unit_pkg::*;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   n_sent;

   c85eu_req_if req_ch ();
   c85eu_rsp_if rsp_ch ();

   exec_scoreboard sb;

   cpu8085_execute_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("Mismatches found");
      $finish;
   end

   // send one operation, with random idle cycles ahead of it
   task automatic send_op(logic [6:0] act, logic [2:0] dst, logic [2:0] src,
                          logic [1:0] pr, logic [15:0] imm);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.action <= act;
      req_ch.dst_reg <= dst;
      req_ch.src_reg <= src;
      req_ch.pair <= pr;
      req_ch.imm <= imm;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_operation(act, dst, src, pr, imm);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [6:0] act;
      logic [15:0] imm;
      int k;
      k = $urandom_range(99);
      if (k < 3) act = 7'($urandom_range(127, 71));
      else act = 7'($urandom_range(70));
      // keep stack and memory traffic in a small window so reads find written data
      imm = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40) + 16'hFFE0);
      if (act == OP_LXI && $urandom_range(1)) imm = 16'hFFE0 + 16'($urandom_range(31));
      send_op(act, 3'($urandom), 3'($urandom), 2'($urandom), imm);
   endtask

   task automatic run_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (count) send_random();
   endtask

   // receiver: sample at the rising edge, change ready at the falling edge
   initial begin
      state_word_type got;
      rsp_ch.ready = 0;
      @(negedge clock);
      forever begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.acc, rsp_ch.reg_bc, rsp_ch.reg_de, rsp_ch.reg_hl,
                   rsp_ch.stack_ptr, rsp_ch.prog_counter, rsp_ch.flags,
                   rsp_ch.port_wr, rsp_ch.port_addr, rsp_ch.port_data};
            sb.check_state(got);
         end
         @(negedge clock);
      end
   end

   initial begin
      int op;
      sb = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      n_sent = 0;
      reset = 1;
      req_ch.valid = 0;
      req_ch.action = OP_NOP;
      req_ch.dst_reg = 0;
      req_ch.src_reg = 0;
      req_ch.pair = 0;
      req_ch.imm = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, M operand, unused pair, stack round trips, DAA, high ports
      send_op(OP_LXI, 0, 0, PAIR_HL, 16'hFFFF);
      send_op(OP_MVI, REG_M, 0, 0, 16'h00FF);
      send_op(OP_INR, REG_M, 0, 0, 0);
      send_op(OP_MVI, REG_A, 0, 0, 16'h0099);
      send_op(OP_ADI, 0, 0, 0, 16'h0099);
      send_op(OP_DAA, 0, 0, 0, 0);
      send_op(OP_SPHL, 0, 0, 0, 0);
      send_op(OP_CALL, 0, 0, 0, 16'h1234);
      send_op(OP_RST, 0, 0, 0, 16'hFFFF);
      send_op(OP_RET, 0, 0, 0, 0);
      send_op(OP_RET, 0, 0, 0, 0);
      send_op(OP_PUSH, 0, 0, PAIR_NONE, 0);
      send_op(OP_POP, 0, 0, PAIR_NONE, 0);
      send_op(OP_INX, 0, 0, PAIR_NONE, 0);
      send_op(OP_DAD, 0, 0, PAIR_HL, 0);
      send_op(OP_SHLD, 0, 0, 0, 16'hFFFF);
      send_op(OP_LHLD, 0, 0, 0, 16'hFFFF);
      send_op(OP_OUT, 0, 0, 0, 16'hFFFF);
      send_op(OP_IN, 0, 0, 0, 16'h00FF);
      send_op(OP_SBB, 0, REG_M, 0, 0);
      send_op(OP_PCHL, 0, 0, 0, 0);
      send_op(7'd127, 0, 0, 0, 0);
      for (op = 0; op <= 70; op += 4) send_op(7'(op), 3'(op), 3'(op + 3), 2'(op), 16'($urandom));

      run_phase(0, 0, 400);
      run_phase(82, 0, 300);
      run_phase(0, 82, 300);
      run_phase(14, 14, 400);
      req_ch.valid <= 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d operations, checked %0d results across four idling phases",
               n_sent, sb.n_checked);
      if (sb.n_errors == 0 && sb.pending.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+src
src/c85eu_pkg.sv
src/c85eu_intf.sv
src/c85eu_front.sv
src/c85eu_back.sv
src/cpu8085_execute_unit.sv
tb/tb_cpu8085_execute_unit_pkg.sv
tb/tb_cpu8085_execute_unit.sv
